// ===== sv/edu_pkg.sv =====
package edu_pkg;

   // Default number of stored pattern symbols and fixed field widths.
   localparam int unsigned MAX_LEN_DEFAULT = 64;
   localparam int unsigned SYM_W = 8;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned DIST_W = 7;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

   // Operation codes carried by a token along the cell chain.
   localparam logic [1:0] OP_RESET  = 2'd0;
   localparam logic [1:0] OP_TEXT   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [SYM_W-1:0] symbol;
   } request_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } response_type;

   // Control part of a token that moves one cell per cycle while the chain advances.
   typedef struct packed {
      logic             valid;
      logic [1:0]       op;
      logic [SYM_W-1:0] symbol;
      logic             dropped;
   } token_ctl_type;

endpackage

// ===== sv/edu_cell.sv =====
module edu_cell #(
   parameter int unsigned MAX_LEN = edu_pkg::MAX_LEN_DEFAULT,
   parameter int unsigned INDEX = 1,
   localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       wr_en,
   input  logic [edu_pkg::SYM_W-1:0]  wr_symbol,
   input  edu_pkg::token_ctl_type     ctl_in,
   input  logic [LW-1:0]              left_in,
   input  logic [LW-1:0]              diag_in,
   input  logic [LW-1:0]              len_in,
   input  logic [LW-1:0]              result_in,
   output edu_pkg::token_ctl_type     ctl_out,
   output logic [LW-1:0]              left_out,
   output logic [LW-1:0]              diag_out,
   output logic [LW-1:0]              len_out,
   output logic [LW-1:0]              result_out
);
   import edu_pkg::*;

   localparam logic [LW-1:0] MY_INIT = LW'(INDEX);

   logic [SYM_W-1:0] sym_ff;
   logic [LW-1:0]    cost_ff;
   logic [LW-1:0]    cost_in;
   token_ctl_type    ctl_ff;
   logic [LW-1:0]    left_ff;
   logic [LW-1:0]    left_in_nx;
   logic [LW-1:0]    diag_ff;
   logic [LW-1:0]    diag_in_nx;
   logic [LW-1:0]    len_ff;
   logic [LW-1:0]    result_ff;
   logic [LW-1:0]    result_in_nx;
   logic [LW:0]      up_cost;
   logic [LW:0]      left_cost;
   logic [LW:0]      sub_cost;
   logic [LW:0]      best;

   // Three candidate costs, one bit wider so that a full-length column cannot wrap.
   always_comb begin
      up_cost   = {1'b0, cost_ff} + (LW+1)'(1);
      left_cost = {1'b0, left_in} + (LW+1)'(1);
      sub_cost  = {1'b0, diag_in} + (LW+1)'(sym_ff != ctl_in.symbol);
      best      = up_cost;
      if (left_cost < best) begin
         best = left_cost;
      end
      if (sub_cost < best) begin
         best = sub_cost;
      end
   end

   // Next cost and the values handed to the next cell.
   always_comb begin
      cost_in      = cost_ff;
      left_in_nx   = left_in;
      diag_in_nx   = diag_in;
      result_in_nx = result_in;
      if (ctl_in.valid) begin
         unique case (ctl_in.op)
            OP_RESET: begin
               cost_in = MY_INIT;
            end
            OP_TEXT: begin
               cost_in    = LW'(best);
               left_in_nx = LW'(best);
               diag_in_nx = cost_ff;
            end
            OP_FINISH: begin
               if (len_in == MY_INIT) begin
                  result_in_nx = cost_ff;
               end
               cost_in = MY_INIT;
            end
            default: begin
               cost_in = cost_ff;
            end
         endcase
      end
   end

   // Token and stored cost; only the valid bit and the cost need a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
         cost_ff      <= MY_INIT;
      end else if (adv) begin
         ctl_ff    <= ctl_in;
         cost_ff   <= cost_in;
         left_ff   <= left_in_nx;
         diag_ff   <= diag_in_nx;
         len_ff    <= len_in;
         result_ff <= result_in_nx;
      end
   end

   // Pattern symbol held by this cell.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sym_ff <= wr_symbol;
      end
   end

   assign ctl_out    = ctl_ff;
   assign left_out   = left_ff;
   assign diag_out   = diag_ff;
   assign len_out    = len_ff;
   assign result_out = result_ff;

endmodule

// ===== sv/edit_distance_unit.sv =====
// Only a finish request gives a response. Throughput: one request per cycle; each
// request but a dropped text request travels the chain of MAX_LEN cells, one cell per
// cycle unless stalled, so the chain holds up to MAX_LEN + 1 requests at once.
// Requests stall only while a finished response waits at the full output register.
// Reset is synchronous and clears lengths, counters, flags, costs and all valid bits.
module edit_distance_unit #(
   parameter int unsigned MAX_LEN = edu_pkg::MAX_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  edu_pkg::request_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output edu_pkg::response_type rsp_data
);
   import edu_pkg::*;

   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_LEN);

   token_ctl_type   ctl_chain    [0:MAX_LEN];
   logic [LW-1:0]   left_chain   [0:MAX_LEN];
   logic [LW-1:0]   diag_chain   [0:MAX_LEN];
   logic [LW-1:0]   len_chain    [0:MAX_LEN];
   logic [LW-1:0]   result_chain [0:MAX_LEN];

   logic            adv;
   logic            req_accept;
   logic            append_wr;
   logic [LW-1:0]   len_ff;
   logic [LW-1:0]   len_in;
   logic [LW-1:0]   tc_ff;
   logic [LW-1:0]   tc_in;
   logic            drop_ff;
   logic            drop_in;
   token_ctl_type   tok_ctl_ff;
   token_ctl_type   tok_ctl_in;
   logic [LW-1:0]   tok_left_ff;
   logic [LW-1:0]   tok_left_in;
   logic [LW-1:0]   tok_diag_ff;
   logic [LW-1:0]   tok_diag_in;
   logic [LW-1:0]   tok_len_ff;
   logic [LW-1:0]   tok_len_in;
   logic [LW-1:0]   tok_result_ff;
   logic [LW-1:0]   tok_result_in;
   logic            last_finish;
   logic            rsp_valid_ff;
   response_type    rsp_data_ff;

   // The chain moves unless a finished token cannot enter the busy output register.
   assign last_finish = ctl_chain[MAX_LEN].valid && (ctl_chain[MAX_LEN].op == OP_FINISH);
   assign adv         = !(last_finish && rsp_valid_ff && rsp_stall);
   assign req_stall   = !adv;
   assign req_accept  = req_valid && !req_stall;

   // Request decode: update lengths and flags, and build the token for the first cell.
   always_comb begin
      len_in        = len_ff;
      tc_in         = tc_ff;
      drop_in       = drop_ff;
      append_wr     = 1'b0;
      tok_ctl_in    = '0;
      tok_left_in   = tc_ff + LW'(1);
      tok_diag_in   = tc_ff;
      tok_len_in    = len_ff;
      tok_result_in = tc_ff;
      tok_ctl_in.symbol  = req_data.symbol;
      tok_ctl_in.dropped = drop_ff;
      if (req_accept) begin
         unique case (req_data.command)
            CMD_CLEAR: begin
               len_in           = '0;
               tc_in            = '0;
               drop_in          = 1'b0;
               tok_ctl_in.valid = 1'b1;
               tok_ctl_in.op    = OP_RESET;
            end
            CMD_APPEND: begin
               if (len_ff < LEN_LIMIT) begin
                  len_in    = len_ff + LW'(1);
                  append_wr = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               tc_in            = '0;
               tok_ctl_in.valid = 1'b1;
               tok_ctl_in.op    = OP_RESET;
            end
            CMD_TEXT: begin
               if (tc_ff < LEN_LIMIT) begin
                  tc_in            = tc_ff + LW'(1);
                  tok_ctl_in.valid = 1'b1;
                  tok_ctl_in.op    = OP_TEXT;
               end else begin
                  drop_in = 1'b1;
               end
            end
            CMD_FINISH: begin
               tc_in            = '0;
               tok_ctl_in.valid = 1'b1;
               tok_ctl_in.op    = OP_FINISH;
            end
            default: begin
               tok_ctl_in.valid = 1'b0;
            end
         endcase
      end
   end

   // Head control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         tc_ff   <= '0;
         drop_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         tc_ff   <= tc_in;
         drop_ff <= drop_in;
      end
   end

   // Head token; only its valid bit needs a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ctl_ff    <= tok_ctl_in;
         tok_left_ff   <= tok_left_in;
         tok_diag_ff   <= tok_diag_in;
         tok_len_ff    <= tok_len_in;
         tok_result_ff <= tok_result_in;
      end
   end

   assign ctl_chain[0]    = tok_ctl_ff;
   assign left_chain[0]   = tok_left_ff;
   assign diag_chain[0]   = tok_diag_ff;
   assign len_chain[0]    = tok_len_ff;
   assign result_chain[0] = tok_result_ff;

   // One cell per pattern position; cell k holds pattern symbol k and row cost k + 1.
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      logic cell_wr;

      assign cell_wr = append_wr && (len_ff == LW'(k));

      edu_cell #(
         .MAX_LEN (MAX_LEN),
         .INDEX   (k + 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .wr_en      (cell_wr),
         .wr_symbol  (req_data.symbol),
         .ctl_in     (ctl_chain[k]),
         .left_in    (left_chain[k]),
         .diag_in    (diag_chain[k]),
         .len_in     (len_chain[k]),
         .result_in  (result_chain[k]),
         .ctl_out    (ctl_chain[k+1]),
         .left_out   (left_chain[k+1]),
         .diag_out   (diag_chain[k+1]),
         .len_out    (len_chain[k+1]),
         .result_out (result_chain[k+1])
      );
   end

   // Output register, loaded when a finish token leaves the chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && last_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_finish) begin
         rsp_data_ff.distance <= DIST_W'(result_chain[MAX_LEN]);
         rsp_data_ff.overflow <= ctl_chain[MAX_LEN].dropped;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/edu_checker.sv =====
module edu_checker #(
   parameter int unsigned MAX_LEN = edu_pkg::MAX_LEN_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input edu_pkg::request_type  req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input edu_pkg::response_type rsp_data
);
   import edu_pkg::*;

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled request stays offered and keeps its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // A stalled response stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Requests are held back only by a response waiting at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stall without a blocked response");

   // A distance never exceeds the longest sequence that can be stored.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.distance) <= MAX_LEN))
      else $error("distance out of range");

endmodule

bind edit_distance_unit edu_checker #(.MAX_LEN(MAX_LEN)) u_edu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
